[rtl/lrks_pkg.sv]
// lrks_pkg: shared types and constants for the recent key set.
// Used by every module under rtl/; depends on nothing.
package lrks_pkg;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 64;
   localparam int ENTRY_W = 2 * KEY_W;
   localparam int OCC_W   = 7;

   localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Result of the shared compare unit for one slot read back from the stores.
   typedef struct packed {
      logic key_eq;      // stored key equals the word's key
      logic rank_zero;   // slot is the least recent one
      logic rank_above;  // slot is more recent than the target rank
      logic slot_hit;    // slot is the one being moved to most recent
   } cmp_flags_type;

endpackage

[rtl/lrks_key_mem.sv]
// lrks_key_mem: key storage, one write port and one registered read port.
// Depends on lrks_pkg for the entry width.
module lrks_key_mem import lrks_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int IW    = 6
) (
   input  logic               clock,
   input  logic               we,
   input  logic [IW-1:0]      waddr,
   input  logic [ENTRY_W-1:0] wdata,
   input  logic               re,
   input  logic [IW-1:0]      raddr,
   output logic [ENTRY_W-1:0] rdata
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[rtl/lrks_rank_mem.sv]
// lrks_rank_mem: recency rank of each slot, one write and one registered read port.
// Depends on lrks_pkg by import; all widths come from the parameters.
module lrks_rank_mem import lrks_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int IW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [IW-1:0] waddr,
   input  logic [IW-1:0] wdata,
   input  logic          re,
   input  logic [IW-1:0] raddr,
   output logic [IW-1:0] rdata
);

   logic [IW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[rtl/lrks_cmp.sv]
// lrks_cmp: shared compare unit, applied to one slot per cycle during scan and sweep.
// Depends on lrks_pkg for the key width and the flag struct.
module lrks_cmp import lrks_pkg::*; #(
   parameter int IW = 6
) (
   input  logic [ENTRY_W-1:0] slot_key,
   input  logic [KEY_W-1:0]   key_high,
   input  logic [KEY_W-1:0]   key_low,
   input  logic [IW-1:0]      slot_rank,
   input  logic [IW-1:0]      slot_idx,
   input  logic [IW-1:0]      target_rank,
   input  logic [IW-1:0]      target_slot,
   output cmp_flags_type      flags
);

   always_comb begin
      flags.key_eq     = (slot_key == {key_high, key_low});
      flags.rank_zero  = (slot_rank == '0);
      flags.rank_above = (slot_rank > target_rank);
      flags.slot_hit   = (slot_idx == target_slot);
   end

endmodule

[rtl/lru_recent_key_set.sv]
// lru_recent_key_set: top level, bounded recency-ordered set of 128-bit keys.
// Depends on lrks_pkg, lrks_key_mem, lrks_rank_mem and lrks_cmp.
//
// Usage
//   Command channel: drive req_opcode, req_key_high and req_key_low and raise
//   start; the word is taken at a rising edge with start high and busy low.
//   Opcode query (0) reports whether the key is held and moves a hit to most
//   recent; an all-zero key is ignored. Opcode mark (1) moves a held key to
//   most recent or inserts it, evicting the least recent key when full.
//   Opcode clear (2) empties the set. The unused opcode changes nothing.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_hit,
//   rsp_evicted, rsp_ignored and rsp_occupancy; the receiver cannot stall.
// Sequencing
//   Clear, unused opcode and null query: result one cycle after the word.
//   Query and mark scan the occupied slots through one key/rank read port;
//   a hit or an eviction then re-ranks every occupied slot through the rank
//   store. The result comes in the same cycle that busy drops, and the
//   next word can be taken at the edge that ends it; busy stays high the
//   whole time.
// Reset
//   Synchronous reset empties the set (fill count to zero); key and rank
//   stores are not cleared, only slots below the fill count are ever read.
module lru_recent_key_set import lrks_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [KEY_W-1:0] req_key_high,
   input  logic [KEY_W-1:0] req_key_low,
   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic             rsp_evicted,
   output logic             rsp_ignored,
   output logic [OCC_W-1:0] rsp_occupancy
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;

   // Sequencer state and the word being worked on.
   logic [1:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] kh_ff, kh_in;
   logic [KEY_W-1:0] kl_ff, kl_in;

   // Slot walk: issue pointer and the read in flight.
   logic [CW-1:0]    idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;

   // Scan findings and re-rank target.
   logic             found_ff, found_in;
   logic             evict_ff, evict_in;
   logic [IW-1:0]    tslot_ff, tslot_in;
   logic [IW-1:0]    trank_ff, trank_in;
   logic [IW-1:0]    lru_ff, lru_in;

   logic [CW-1:0]    count_ff, count_in;

   // Result register.
   logic             strobe_ff, strobe_in;
   logic             hit_ff, hit_in;
   logic             ev_ff, ev_in;
   logic             ign_ff, ign_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // Store ports.
   logic               key_we;
   logic [IW-1:0]      key_waddr;
   logic               rd_en;
   logic [ENTRY_W-1:0] key_q;
   logic               rank_we;
   logic [IW-1:0]      rank_waddr;
   logic [IW-1:0]      rank_wdata;
   logic [IW-1:0]      rank_q;

   cmp_flags_type      flags;
   logic               issue;
   logic               walk_done;
   logic               full;
   logic [IW-1:0]      top_rank;

   assign issue     = (idx_ff < count_ff);
   assign walk_done = !issue && !rd_vld_ff;
   assign full      = (count_ff == CW'(CAPACITY));
   assign top_rank  = IW'(count_ff - CW'(1));
   assign rd_en     = issue && (state_ff != S_IDLE);

   lrks_key_mem #(.DEPTH(CAPACITY), .IW(IW)) u_key_mem (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata ({kh_ff, kl_ff}),
      .re    (rd_en),
      .raddr (idx_ff[IW-1:0]),
      .rdata (key_q)
   );

   lrks_rank_mem #(.DEPTH(CAPACITY), .IW(IW)) u_rank_mem (
      .clock (clock),
      .we    (rank_we),
      .waddr (rank_waddr),
      .wdata (rank_wdata),
      .re    (rd_en),
      .raddr (idx_ff[IW-1:0]),
      .rdata (rank_q)
   );

   lrks_cmp #(.IW(IW)) u_cmp (
      .slot_key    (key_q),
      .key_high    (kh_ff),
      .key_low     (kl_ff),
      .slot_rank   (rank_q),
      .slot_idx    (rd_idx_ff),
      .target_rank (trank_ff),
      .target_slot (tslot_ff),
      .flags       (flags)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      kh_in     = kh_ff;
      kl_in     = kl_ff;
      idx_in    = idx_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = idx_ff[IW-1:0];
      found_in  = found_ff;
      evict_in  = evict_ff;
      tslot_in  = tslot_ff;
      trank_in  = trank_ff;
      lru_in    = lru_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      hit_in    = hit_ff;
      ev_in     = ev_ff;
      ign_in    = ign_ff;
      occ_in    = occ_ff;
      key_we     = 1'b0;
      key_waddr  = lru_ff;
      rank_we    = 1'b0;
      rank_waddr = rd_idx_ff;
      rank_wdata = rank_q;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Capture the word; short commands answer on the next cycle.
               op_in = req_opcode;
               kh_in = req_key_high;
               kl_in = req_key_low;
               priority if (req_opcode == OP_CLEAR) begin
                  count_in  = '0;
                  strobe_in = 1'b1;
                  hit_in    = 1'b0;
                  ev_in     = 1'b0;
                  ign_in    = 1'b0;
                  occ_in    = '0;
               end else if (req_opcode == OP_QUERY && req_key_high == '0 &&
                            req_key_low == '0) begin
                  strobe_in = 1'b1;
                  hit_in    = 1'b0;
                  ev_in     = 1'b0;
                  ign_in    = 1'b1;
                  occ_in    = OCC_W'(count_ff);
               end else if (req_opcode == OP_QUERY || req_opcode == OP_MARK) begin
                  state_in = S_SCAN;
                  idx_in   = '0;
                  found_in = 1'b0;
                  evict_in = 1'b0;
               end else begin
                  strobe_in = 1'b1;
                  hit_in    = 1'b0;
                  ev_in     = 1'b0;
                  ign_in    = 1'b0;
                  occ_in    = OCC_W'(count_ff);
               end
            end
         end

         S_SCAN: begin
            // Walk the occupied slots, one compare per cycle.
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (flags.key_eq) begin
                  found_in = 1'b1;
                  tslot_in = rd_idx_ff;
                  trank_in = rank_q;
               end
               if (flags.rank_zero) begin
                  lru_in = rd_idx_ff;
               end
            end
            if (walk_done) begin
               idx_in = '0;
               priority if (found_ff) begin
                  state_in = S_SWEEP;
               end else if (op_ff == OP_MARK && full) begin
                  // Overwrite the least recent slot, then re-rank as if it moved up.
                  key_we    = 1'b1;
                  key_waddr = lru_ff;
                  tslot_in  = lru_ff;
                  trank_in  = '0;
                  evict_in  = 1'b1;
                  state_in  = S_SWEEP;
               end else if (op_ff == OP_MARK) begin
                  // Append into the next free slot as most recent.
                  key_we     = 1'b1;
                  key_waddr  = count_ff[IW-1:0];
                  rank_we    = 1'b1;
                  rank_waddr = count_ff[IW-1:0];
                  rank_wdata = count_ff[IW-1:0];
                  count_in   = count_ff + CW'(1);
                  strobe_in  = 1'b1;
                  hit_in     = 1'b0;
                  ev_in      = 1'b0;
                  ign_in     = 1'b0;
                  occ_in     = OCC_W'(count_ff + CW'(1));
                  state_in   = S_IDLE;
               end else begin
                  strobe_in = 1'b1;
                  hit_in    = 1'b0;
                  ev_in     = 1'b0;
                  ign_in    = 1'b0;
                  occ_in    = OCC_W'(count_ff);
                  state_in  = S_IDLE;
               end
            end
         end

         S_SWEEP: begin
            // Read a rank, write it back in the cycle after the read: drop the ranks above
            // the target by one and put the target slot on top.
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               rank_we    = 1'b1;
               rank_waddr = rd_idx_ff;
               priority if (flags.slot_hit) begin
                  rank_wdata = top_rank;
               end else if (flags.rank_above) begin
                  rank_wdata = rank_q - IW'(1);
               end else begin
                  rank_wdata = rank_q;
               end
            end
            if (walk_done) begin
               idx_in    = '0;
               strobe_in = 1'b1;
               hit_in    = found_ff;
               ev_in     = evict_ff;
               ign_in    = 1'b0;
               occ_in    = OCC_W'(count_ff);
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         strobe_ff <= 1'b0;
         found_ff  <= 1'b0;
         evict_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
         strobe_ff <= strobe_in;
         found_ff  <= found_in;
         evict_ff  <= evict_in;
      end
   end

   // Payload: hold the word, scan findings and result fields.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      kh_ff     <= kh_in;
      kl_ff     <= kl_in;
      rd_idx_ff <= rd_idx_in;
      tslot_ff  <= tslot_in;
      trank_ff  <= trank_in;
      lru_ff    <= lru_in;
      hit_ff    <= hit_in;
      ev_ff     <= ev_in;
      ign_ff    <= ign_in;
      occ_ff    <= occ_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_evicted   = ev_ff;
   assign rsp_ignored   = ign_ff;
   assign rsp_occupancy = occ_ff;

   // Fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // An eviction only happens on a full set and never together with a hit.
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |-> (full && !rsp_hit && !rsp_ignored))
      else $error("eviction on a set that is not full");

   // Clear answers on the next cycle with an empty set.
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_CLEAR) |=>
         (rsp_strobe && rsp_occupancy == '0))
      else $error("clear not answered with empty set");

   // Re-ranking only runs for a hit or an eviction.
   a_sweep_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (found_ff || evict_ff))
      else $error("rank sweep without a target");

endmodule
